FILE: sv/ipb_pkg.sv
// Shared types and constants for the image-to-page-bytes packer.
package ipb_pkg;

    localparam int PIXEL_W     = 8;
    localparam int PAGE_W      = 3;
    localparam int DCOL_W      = 8;
    localparam int BYTE_W      = 8;
    localparam int ROWS_CFG_W  = 7;
    localparam int COLS_CFG_W  = 8;
    localparam int OFFS_CFG_W  = 7;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 8;
    localparam int BIT_W       = 3;

    localparam logic [ROWS_CFG_W-1:0] RST_IMAGE_ROWS    = 7'd64;
    localparam logic [COLS_CFG_W-1:0] RST_IMAGE_COLS    = 8'd128;
    localparam logic [OFFS_CFG_W-1:0] RST_COLUMN_OFFSET = 7'd24;

    localparam logic [BIT_W-1:0] BIT_FIRST = 3'd0;
    localparam logic [BIT_W-1:0] BIT_LAST  = 3'd7;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_ROWS    = 2'd0,
        CFG_IMAGE_COLS    = 2'd1,
        CFG_COLUMN_OFFSET = 2'd2
    } t_cfg_idx;

    // Per-pixel control from the position sequencer
    typedef struct packed {
        logic              emit;
        logic              done;
        logic [PAGE_W-1:0] page;
    } t_pos_ctl;

endpackage

FILE: sv/ipb_acc_mem.sv
// Column accumulator memory: one write port, one registered read port.
module ipb_acc_mem #(
    parameter int DEPTH = 128,
    parameter int AW    = 7
) (
    input  logic                        i_clk,
    input  logic                        i_rd_en,
    input  logic [AW-1:0]               i_rd_addr,
    output logic [ipb_pkg::BYTE_W-1:0]  o_rd_data,
    input  logic                        i_wr_en,
    input  logic [AW-1:0]               i_wr_addr,
    input  logic [ipb_pkg::BYTE_W-1:0]  i_wr_data
);

    logic [ipb_pkg::BYTE_W-1:0] r_mem [DEPTH];
    logic [ipb_pkg::BYTE_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: sv/ipb_seq.sv
// Row/column position sequencer: counters, group boundaries, page and display column.
module ipb_seq #(
    parameter int MAX_COLS = 128,
    parameter int MAX_ROWS = 64,
    parameter int CW       = 7,
    parameter int RW       = 6
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_step,
    input  logic [ipb_pkg::ROWS_CFG_W-1:0]    i_image_rows,
    input  logic [ipb_pkg::COLS_CFG_W-1:0]    i_image_cols,
    input  logic [ipb_pkg::OFFS_CFG_W-1:0]    i_column_offset,
    output logic [CW-1:0]                     o_col,
    output logic [ipb_pkg::BIT_W-1:0]         o_bit,
    output logic [ipb_pkg::DCOL_W-1:0]        o_display_column,
    output ipb_pkg::t_pos_ctl                 o_ctl
);

    localparam logic [8:0] ROWS_CAP = 9'(MAX_ROWS);
    localparam logic [8:0] COLS_CAP = 9'(MAX_COLS);

    logic [RW-1:0] r_row, n_row;
    logic [CW-1:0] r_col, n_col;
    logic [8:0]    rows_lim, cols_lim;
    logic          last_row, last_col;

    // Zero acts as one, oversize saturates at the memory/counter capacity
    always_comb begin
        if (i_image_rows == '0) begin
            rows_lim = 9'd1;
        end else if (9'(i_image_rows) > ROWS_CAP) begin
            rows_lim = ROWS_CAP;
        end else begin
            rows_lim = 9'(i_image_rows);
        end
        if (i_image_cols == '0) begin
            cols_lim = 9'd1;
        end else if (9'(i_image_cols) > COLS_CAP) begin
            cols_lim = COLS_CAP;
        end else begin
            cols_lim = 9'(i_image_cols);
        end
    end

    assign last_row = (9'(r_row) + 9'd1) >= rows_lim;
    assign last_col = (9'(r_col) + 9'd1) >= cols_lim;

    assign o_col            = r_col;
    assign o_bit            = r_row[ipb_pkg::BIT_W-1:0];
    assign o_display_column = 8'(i_column_offset) + 8'(r_col);
    assign o_ctl.emit       = (o_bit == ipb_pkg::BIT_LAST) || last_row;
    assign o_ctl.done       = last_row && last_col;
    assign o_ctl.page       = 3'(r_row >> 3);

    always_comb begin
        n_row = r_row;
        n_col = r_col;
        if (i_step) begin
            if (last_col) begin
                n_col = '0;
                n_row = last_row ? '0 : r_row + RW'(1);
            end else begin
                n_col = r_col + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else begin
            r_row <= n_row;
            r_col <= n_col;
        end
    end

endmodule

FILE: sv/image_to_page_bytes_top.sv
// Top level of the image-to-page-bytes packer: config registers, RMW stage and output register.
//
// Packs a row-major monochrome pixel stream into display page bytes: one pixel is taken
// every clock cycle for any image size, unless a byte is due while the result channel is
// blocked. Each pixel costs one read of its column's byte from the accumulator memory
// (issued on acceptance) and one write back as it leaves the RMW stage; the write of the
// previous pixel is forwarded when both hit the same column (single-column image). A column
// byte passes through the RMW stage and the output register once the pixel that closes its
// eight-row group (or the image) is accepted; the output register lets the input keep
// flowing while a result waits, until the next byte is due. The memory needs no clearing after
// reset: row 0 of each group overwrites its entry. Configuration is to be written by the user
// only while idle (not enforced by the block); a write beyond the register list is ignored.
module image_to_page_bytes_top #(
    parameter int MAX_COLS = 128,
    parameter int MAX_ROWS = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_pix_valid,
    output logic                               o_pix_ready,
    input  logic [ipb_pkg::PIXEL_W-1:0]        i_pixel,
    output logic                               o_res_valid,
    input  logic                               i_res_ready,
    output logic [ipb_pkg::PAGE_W-1:0]         o_page_index,
    output logic [ipb_pkg::DCOL_W-1:0]         o_display_column,
    output logic [ipb_pkg::BYTE_W-1:0]         o_column_byte,
    output logic                               o_image_done,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [ipb_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [ipb_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int CW = $clog2(MAX_COLS);
    localparam int RW = $clog2(MAX_ROWS);

    // Configuration registers
    logic [ipb_pkg::ROWS_CFG_W-1:0] r_image_rows;
    logic [ipb_pkg::COLS_CFG_W-1:0] r_image_cols;
    logic [ipb_pkg::OFFS_CFG_W-1:0] r_column_offset;

    // Read-modify-write stage
    logic                        r_s1_valid;
    logic [CW-1:0]               r_s1_col;
    logic [ipb_pkg::BIT_W-1:0]   r_s1_bit;
    logic                        r_s1_lit;
    ipb_pkg::t_pos_ctl           r_s1_ctl;
    logic [ipb_pkg::DCOL_W-1:0]  r_s1_dcol;
    logic                        r_fwd_hit;
    logic [ipb_pkg::BYTE_W-1:0]  r_fwd_data;

    // Output register
    logic                        r_out_valid;
    logic [ipb_pkg::PAGE_W-1:0]  r_out_page;
    logic [ipb_pkg::DCOL_W-1:0]  r_out_dcol;
    logic [ipb_pkg::BYTE_W-1:0]  r_out_byte;
    logic                        r_out_done;

    logic                        pix_acc;
    logic                        s1_adv;
    logic [CW-1:0]               seq_col;
    logic [ipb_pkg::BIT_W-1:0]   seq_bit;
    logic [ipb_pkg::DCOL_W-1:0]  seq_dcol;
    ipb_pkg::t_pos_ctl           seq_ctl;
    logic [ipb_pkg::BYTE_W-1:0]  mem_rd_data;
    logic [ipb_pkg::BYTE_W-1:0]  acc_old;
    logic [ipb_pkg::BYTE_W-1:0]  s1_acc;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_rows    <= ipb_pkg::RST_IMAGE_ROWS;
            r_image_cols    <= ipb_pkg::RST_IMAGE_COLS;
            r_column_offset <= ipb_pkg::RST_COLUMN_OFFSET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                ipb_pkg::CFG_IMAGE_ROWS: begin
                    r_image_rows <= i_cfg_data[ipb_pkg::ROWS_CFG_W-1:0];
                end
                ipb_pkg::CFG_IMAGE_COLS: begin
                    r_image_cols <= i_cfg_data[ipb_pkg::COLS_CFG_W-1:0];
                end
                ipb_pkg::CFG_COLUMN_OFFSET: begin
                    r_column_offset <= i_cfg_data[ipb_pkg::OFFS_CFG_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Stage 1 moves on unless it has a byte to emit and the output is blocked
    assign s1_adv      = r_s1_valid && (!r_s1_ctl.emit || !r_out_valid || i_res_ready);
    assign o_pix_ready = !r_s1_valid || s1_adv;
    assign pix_acc     = i_pix_valid && o_pix_ready;

    ipb_seq #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS),
        .CW       (CW),
        .RW       (RW)
    ) u_seq (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_step           (pix_acc),
        .i_image_rows     (r_image_rows),
        .i_image_cols     (r_image_cols),
        .i_column_offset  (r_column_offset),
        .o_col            (seq_col),
        .o_bit            (seq_bit),
        .o_display_column (seq_dcol),
        .o_ctl            (seq_ctl)
    );

    ipb_acc_mem #(
        .DEPTH (MAX_COLS),
        .AW    (CW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rd_en   (pix_acc),
        .i_rd_addr (seq_col),
        .o_rd_data (mem_rd_data),
        .i_wr_en   (s1_adv),
        .i_wr_addr (r_s1_col),
        .i_wr_data (s1_acc)
    );

    // Row 0 of a group starts the byte afresh
    always_comb begin
        if (r_s1_bit == ipb_pkg::BIT_FIRST) begin
            acc_old = '0;
        end else if (r_fwd_hit) begin
            acc_old = r_fwd_data;
        end else begin
            acc_old = mem_rd_data;
        end
        s1_acc = acc_old;
        if (r_s1_lit) begin
            s1_acc = acc_old | (8'd1 << r_s1_bit);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (pix_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pix_acc) begin
            r_s1_col   <= seq_col;
            r_s1_bit   <= seq_bit;
            r_s1_lit   <= (i_pixel != '0);
            r_s1_ctl   <= seq_ctl;
            r_s1_dcol  <= seq_dcol;
            // write landing in the same cycle as this read: memory returns stale data
            r_fwd_hit  <= s1_adv && (r_s1_col == seq_col);
            r_fwd_data <= s1_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv && r_s1_ctl.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_ctl.emit) begin
            r_out_page <= r_s1_ctl.page;
            r_out_dcol <= r_s1_dcol;
            r_out_byte <= s1_acc;
            r_out_done <= r_s1_ctl.done;
        end
    end

    assign o_res_valid      = r_out_valid;
    assign o_page_index     = r_out_page;
    assign o_display_column = r_out_dcol;
    assign o_column_byte    = r_out_byte;
    assign o_image_done     = r_out_done;

endmodule
